// ===== rtl/core/packet_deframe_sum16_check_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the packet deframer / sum16 checker
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PACKET_DEFRAME_SUM16_CHECK_CORE_MACROS_SVH
`define PACKET_DEFRAME_SUM16_CHECK_CORE_MACROS_SVH

// same-cycle implication
`define PDSC_ASSERT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("pdsc assertion failed");

// next-cycle implication
`define PDSC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("pdsc assertion failed");

`endif

// ===== rtl/core/pdsc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdsc_pkg
// Shared constants and types for the packet deframer / sum16 checker.
// ----------------------------------------------------------------------------
package pdsc_pkg;

	localparam int ByteW          = 8;
	localparam int WordW          = 16;
	localparam int HdrGeneral     = 6;
	localparam int HdrAdmin       = 7;
	localparam int PayloadBytesDef = 256;

	// one result item
	typedef struct packed {
		logic [ByteW-1:0] payload_byte;
		logic             payload_valid;
		logic [ByteW-1:0] payload_index;
		logic             done_res;
		logic             packet_ok;
		logic             too_short;
		logic [WordW-1:0] lead_word;
		logic [ByteW-1:0] origin_host;
		logic [WordW-1:0] action_word;
		logic [WordW-1:0] received_sum;
	} pdsc_result_t;

endpackage

// ===== rtl/core/pdsc_channels.sv =====
// ----------------------------------------------------------------------------
// pdsc channels
// Valid/ready stream interfaces for received bytes and result items.
// ----------------------------------------------------------------------------
interface pdsc_in_if import pdsc_pkg::*;;
	logic             valid;
	logic             ready;
	logic [ByteW-1:0] rx_byte;
	logic             last_byte;

	modport source (output valid, rx_byte, last_byte, input ready);
	modport sink   (input valid, rx_byte, last_byte, output ready);
endinterface

interface pdsc_out_if import pdsc_pkg::*;;
	logic             valid;
	logic             ready;
	logic [ByteW-1:0] payload_byte;
	logic             payload_valid;
	logic [ByteW-1:0] payload_index;
	logic             done_res;
	logic             packet_ok;
	logic             too_short;
	logic [WordW-1:0] lead_word;
	logic [ByteW-1:0] origin_host;
	logic [WordW-1:0] action_word;
	logic [WordW-1:0] received_sum;

	modport source (output valid, payload_byte, payload_valid, payload_index, done_res,
		packet_ok, too_short, lead_word, origin_host, action_word, received_sum,
		input ready);
	modport sink   (input valid, payload_byte, payload_valid, payload_index, done_res,
		packet_ok, too_short, lead_word, origin_host, action_word, received_sum,
		output ready);
endinterface

// ===== rtl/core/packet_deframe_sum16_check_core.sv =====
// ----------------------------------------------------------------------------
// packet_deframe_sum16_check_core
// Byte-stream packet deframer with 16-bit additive checksum check.
//
//   channel  dir  handshake     payload
//   rx       in   valid/ready   rx_byte, last_byte
//   res      out  valid/ready   payload fields, done/status, header words
//
// One item per cycle sustained while res.ready holds high; an accepted item
// passes the input register and then the result register, where res.valid rises.
// Stage 1 is the input register; the step into the result register updates
// the position counter, header holds and running sum together.
// Reset clears the format register, the packet state and both valid flags.
// A stalled result holds in the output register; stage 1 keeps taking
// items until it is also full, then rx.ready drops.
// ----------------------------------------------------------------------------
module packet_deframe_sum16_check_core import pdsc_pkg::*; #(
	parameter int PAYLOAD_BYTES = PayloadBytesDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	pdsc_in_if.sink           rx,
	pdsc_out_if.source        res
);

	logic             format_q;
	logic             v_s1;
	logic [ByteW-1:0] rx_byte_s1;
	logic             last_s1;
	logic             v_s2;
	pdsc_result_t     res_s2;
	pdsc_result_t     res_c;
	logic             adv_s2;
	logic             step;

	// handshake
	assign adv_s2   = !v_s2 || res.ready;
	assign step     = v_s1 && adv_s2;
	assign rx.ready = !v_s1 || step;

	// format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= 1'b0;
		end else if (cfg_we) begin
			format_q <= cfg_wdata;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rx.ready) begin
			v_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			rx_byte_s1 <= rx.rx_byte;
			last_s1    <= rx.last_byte;
		end
	end

	pdsc_frame_state #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.admin     (format_q),
		.rx_byte   (rx_byte_s1),
		.last_byte (last_s1),
		.res       (res_c)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res_c;
		end
	end

	assign res.valid         = v_s2;
	assign res.payload_byte  = res_s2.payload_byte;
	assign res.payload_valid = res_s2.payload_valid;
	assign res.payload_index = res_s2.payload_index;
	assign res.done_res      = res_s2.done_res;
	assign res.packet_ok     = res_s2.packet_ok;
	assign res.too_short     = res_s2.too_short;
	assign res.lead_word     = res_s2.lead_word;
	assign res.origin_host   = res_s2.origin_host;
	assign res.action_word   = res_s2.action_word;
	assign res.received_sum  = res_s2.received_sum;

endmodule

// ===== rtl/core/pdsc_frame_state.sv =====
// ----------------------------------------------------------------------------
// pdsc_frame_state
// Per-packet state: byte position, header capture, running sum and the
// result for the byte being stepped.
// ----------------------------------------------------------------------------
`include "packet_deframe_sum16_check_core_macros.svh"

module pdsc_frame_state import pdsc_pkg::*; #(
	parameter int PAYLOAD_BYTES = PayloadBytesDef
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             admin,
	input  logic [ByteW-1:0] rx_byte,
	input  logic             last_byte,
	output pdsc_result_t     res
);

	localparam int PosW = $clog2(HdrAdmin + PAYLOAD_BYTES + 1);
	localparam logic [PosW-1:0] HdrGenP  = PosW'(HdrGeneral);
	localparam logic [PosW-1:0] HdrAdmP  = PosW'(HdrAdmin);
	localparam logic [PosW-1:0] LimitGen = PosW'(HdrGeneral + PAYLOAD_BYTES);
	localparam logic [PosW-1:0] LimitAdm = PosW'(HdrAdmin + PAYLOAD_BYTES);

	// header byte meaning, independent of layout
	typedef enum logic [2:0] {
		SLOT_LEAD_HI,
		SLOT_LEAD_LO,
		SLOT_ORIGIN,
		SLOT_ACT_HI,
		SLOT_ACT_LO,
		SLOT_SUM_HI,
		SLOT_SUM_LO
	} hdr_slot_t;

	logic [PosW-1:0]  pos_q, pos_n;
	logic [WordW-1:0] sum_q, sum_n;
	logic [WordW-1:0] lead_q, lead_n;
	logic [ByteW-1:0] origin_q, origin_n;
	logic [WordW-1:0] action_q, action_n;
	logic [WordW-1:0] chk_q, chk_n;

	logic [PosW-1:0]  hdr_len;
	logic [PosW-1:0]  limit;
	logic [PosW-1:0]  pay_off;
	logic             in_hdr;
	logic             in_pay;
	logic             short_pkt;
	logic [2:0]       slot_code;
	hdr_slot_t        slot;
	logic [ByteW-1:0] origin_rep;
	logic [WordW-1:0] total;

	// position decode
	always_comb begin
		hdr_len   = admin ? HdrAdmP : HdrGenP;
		limit     = admin ? LimitAdm : LimitGen;
		in_hdr    = pos_q < hdr_len;
		in_pay    = !in_hdr && (pos_q < limit);
		pay_off   = pos_q - hdr_len;
		short_pkt = pos_q < (hdr_len - PosW'(1));
		pos_n     = (pos_q < limit) ? pos_q + PosW'(1) : pos_q;
		// general layout has no origin byte
		if (admin || pos_q[2:0] < 3'd2) begin
			slot_code = pos_q[2:0];
		end else begin
			slot_code = pos_q[2:0] + 3'd1;
		end
		slot = hdr_slot_t'(slot_code);
	end

	// header capture and running sum
	always_comb begin
		lead_n   = lead_q;
		origin_n = origin_q;
		action_n = action_q;
		chk_n    = chk_q;
		if (in_hdr) begin
			case (slot)
				SLOT_LEAD_HI: lead_n[15:8]   = rx_byte;
				SLOT_LEAD_LO: lead_n[7:0]    = rx_byte;
				SLOT_ORIGIN:  origin_n       = rx_byte;
				SLOT_ACT_HI:  action_n[15:8] = rx_byte;
				SLOT_ACT_LO:  action_n[7:0]  = rx_byte;
				SLOT_SUM_HI:  chk_n[15:8]    = rx_byte;
				SLOT_SUM_LO:  chk_n[7:0]     = rx_byte;
				default:      chk_n          = chk_q;
			endcase
		end
		sum_n      = in_pay ? sum_q + {{(WordW-ByteW){1'b0}}, rx_byte} : sum_q;
		origin_rep = admin ? origin_n : '0;
		total      = sum_n + lead_n + {{(WordW-ByteW){1'b0}}, origin_rep} + action_n;
	end

	// result item for this byte
	always_comb begin
		res = '0;
		if (in_pay) begin
			res.payload_byte  = rx_byte;
			res.payload_valid = 1'b1;
			res.payload_index = ByteW'(pay_off);
		end
		if (last_byte) begin
			res.done_res     = 1'b1;
			res.packet_ok    = !short_pkt && (total == chk_n);
			res.too_short    = short_pkt;
			res.lead_word    = lead_n;
			res.origin_host  = origin_rep;
			res.action_word  = action_n;
			res.received_sum = chk_n;
		end
	end

	// state update; packet state clears after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			sum_q    <= '0;
			lead_q   <= '0;
			origin_q <= '0;
			action_q <= '0;
			chk_q    <= '0;
		end else if (step) begin
			if (last_byte) begin
				pos_q    <= '0;
				sum_q    <= '0;
				lead_q   <= '0;
				origin_q <= '0;
				action_q <= '0;
				chk_q    <= '0;
			end else begin
				pos_q    <= pos_n;
				sum_q    <= sum_n;
				lead_q   <= lead_n;
				origin_q <= origin_n;
				action_q <= action_n;
				chk_q    <= chk_n;
			end
		end
	end

	`PDSC_ASSERT(a_pos_bound, clk, arst_n, 1'b1, pos_q <= LimitAdm)
	`PDSC_ASSERT_NEXT(a_clear_after_last, clk, arst_n, step && last_byte, pos_q == '0 && sum_q == '0)
	`PDSC_ASSERT(a_payload_not_short, clk, arst_n, res.payload_valid, !res.too_short)
	`PDSC_ASSERT(a_status_only_done, clk, arst_n, !res.done_res, !res.packet_ok && res.lead_word == '0)

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: packet deframer with 16-bit additive checksum
// Drives packets a byte at a time through the rx stream and checks every
// result item against a cycle-free predictor of the deframer. A short
// directed table (reset state, field extremes, short packets, a format
// switch inside a packet) is followed by randomized packets in both layouts,
// mostly with good checksums and random content. Both streams idle and
// stall at random.
// ----------------------------------------------------------------------------
module testbench;
	import pdsc_pkg::*;

	localparam int   PayloadLen  = PayloadBytesDef;
	localparam int   RandomItems = 1100;
	localparam int   IdleLimit   = 2000;
	localparam int   TailCycles  = 10;
	localparam logic FMT_GENERAL = 1'b0;
	localparam logic FMT_ADMIN   = 1'b1;

	typedef enum logic {ROW_BYTE, ROW_FORMAT} row_kind_t;

	// one line of the directed table; format rows carry the format in data[0]
	typedef struct {
		row_kind_t    kind;
		logic [7:0]   data;
		logic         last;
		bit           typed;
		pdsc_result_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	pdsc_in_if  rx_ch ();
	pdsc_out_if res_ch ();

	packet_deframe_sum16_check_core #(
		.PAYLOAD_BYTES(PayloadLen)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.rx       (rx_ch),
		.res      (res_ch)
	);

	// predictor state: format register and the packet being assembled
	logic        cur_fmt;
	int          byte_cnt;
	logic [15:0] sum_acc;
	logic [15:0] lead_cap;
	logic [7:0]  origin_cap;
	logic [15:0] action_cap;
	logic [15:0] chk_cap;

	pdsc_result_t expect_q[$];
	stim_row_t    plan[$];

	int error_count;
	int checked_results;
	int packets_seen;
	int ok_count;
	int short_count;
	int fmt_writes;
	int directed_items;
	int random_items;
	int src_calm;
	int snk_calm;
	int stall_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// expected result for one byte; advances the predictor state
	function automatic pdsc_result_t deframe_step(logic [7:0] b, logic last);
		pdsc_result_t r;
		int           hdr;
		int           limit;
		int           pos;
		int           k;
		bit           admin;
		logic [7:0]   org;
		logic [15:0]  total;
		r = '0;
		admin = (cur_fmt == FMT_ADMIN);
		hdr = admin ? HdrAdmin : HdrGeneral;
		limit = hdr + PayloadLen;
		pos = byte_cnt;
		if (pos < hdr) begin
			if (admin && pos == 2) begin
				origin_cap = b;
			end else begin
				// admin header is the general one with the origin octet inserted
				k = (admin && pos > 2) ? pos - 1 : pos;
				case (k)
					0: lead_cap[15:8] = b;
					1: lead_cap[7:0] = b;
					2: action_cap[15:8] = b;
					3: action_cap[7:0] = b;
					4: chk_cap[15:8] = b;
					default: chk_cap[7:0] = b;
				endcase
			end
		end else if (pos < limit) begin
			sum_acc = sum_acc + 16'(b);
			r.payload_byte = b;
			r.payload_valid = 1'b1;
			r.payload_index = 8'(pos - hdr);
		end
		if (pos < limit)
			byte_cnt = pos + 1;
		if (last) begin
			org = admin ? origin_cap : 8'h00;
			total = sum_acc + lead_cap + 16'(org) + action_cap;
			r.done_res = 1'b1;
			r.too_short = (pos + 1 < hdr);
			r.packet_ok = !r.too_short && (total == chk_cap);
			r.lead_word = lead_cap;
			r.origin_host = org;
			r.action_word = action_cap;
			r.received_sum = chk_cap;
			byte_cnt = 0;
			sum_acc = '0;
			lead_cap = '0;
			origin_cap = '0;
			action_cap = '0;
			chk_cap = '0;
		end
		return r;
	endfunction

	// status result of a last byte, for table rows typed in by hand
	function automatic pdsc_result_t packet_status(logic [7:0] pb, logic pv, logic [7:0] pi,
			logic ok, logic short_pkt, logic [15:0] lead, logic [7:0] origin,
			logic [15:0] action, logic [15:0] rsum);
		return '{pb, pv, pi, 1'b1, ok, short_pkt, lead, origin, action, rsum};
	endfunction

	function automatic stim_row_t row(row_kind_t kind, logic [7:0] data, logic last = 1'b0,
			bit typed = 1'b0, pdsc_result_t want = '0);
		stim_row_t s;
		s.kind = kind;
		s.data = data;
		s.last = last;
		s.typed = typed;
		s.want = want;
		return s;
	endfunction

	// idle cycles before the next item; occasionally a stretch with none
	function automatic int idle_cycles(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			calm_left = $urandom_range(16, 48);
			return 0;
		end
		return $urandom_range(0, 16);
	endfunction

	task automatic field_check(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			error_count++;
		end
	endtask

	// present one byte, wait for it to be taken, queue its expected result
	task automatic send_byte(logic [7:0] b, logic last, bit typed = 1'b0,
			pdsc_result_t want = '0);
		int           gap;
		pdsc_result_t pred;
		gap = idle_cycles(src_calm);
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		rx_ch.last_byte <= last;
		do @(posedge clk); while (rx_ch.ready !== 1'b1);
		pred = deframe_step(b, last);
		expect_q.push_back(typed ? want : pred);
	endtask

	// hold off the sender until every queued result has come back
	task automatic drain();
		rx_ch.valid <= 1'b0;
		while (expect_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_format(logic v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_fmt = v;
		fmt_writes++;
	endtask

	// one random packet: mostly well formed, some with a bad checksum, some noise
	task automatic random_packet(bit force_long);
		logic [7:0]  pkt[$];
		logic [7:0]  body[$];
		logic [7:0]  b;
		logic [15:0] lead;
		logic [15:0] action;
		logic [15:0] chk;
		logic [7:0]  origin;
		int          hdr;
		int          plen;
		int          style;
		int          split;
		bit          admin;
		admin = (cur_fmt == FMT_ADMIN);
		hdr = admin ? HdrAdmin : HdrGeneral;
		style = force_long ? 0 : $urandom_range(0, 19);
		if (style >= 17) begin
			plen = $urandom_range(1, hdr + 3);
			repeat (plen) pkt.push_back(8'($urandom));
		end else begin
			if (force_long)
				plen = $urandom_range(PayloadLen + 4, PayloadLen + 20);
			else if ($urandom_range(0, 14) == 0)
				plen = $urandom_range(PayloadLen - 16, PayloadLen + 20);
			else
				plen = $urandom_range(0, 12);
			lead = 16'($urandom);
			action = 16'($urandom);
			origin = 8'($urandom);
			chk = lead + action + (admin ? 16'(origin) : 16'h0000);
			for (int k = 0; k < plen; k++) begin
				b = 8'($urandom);
				body.push_back(b);
				if (k < PayloadLen)
					chk = chk + 16'(b);
			end
			if (style >= 14)
				chk = chk ^ (16'h0001 << $urandom_range(0, 15));
			pkt.push_back(lead[15:8]);
			pkt.push_back(lead[7:0]);
			if (admin)
				pkt.push_back(origin);
			pkt.push_back(action[15:8]);
			pkt.push_back(action[7:0]);
			pkt.push_back(chk[15:8]);
			pkt.push_back(chk[7:0]);
			foreach (body[k])
				pkt.push_back(body[k]);
		end
		// now and then the format flips while the packet is in flight
		split = -1;
		if (pkt.size() > 1 && $urandom_range(0, 14) == 0)
			split = $urandom_range(1, pkt.size() - 1);
		foreach (pkt[k]) begin
			if (k == split)
				write_format(1'($urandom));
			send_byte(pkt[k], k == pkt.size() - 1);
			if (k < hdr + PayloadLen)
				random_items++;
		end
	endtask

	// result side: random stalls, in-order compare against the oldest expectation
	initial begin : result_sink
		int           gap;
		pdsc_result_t got;
		pdsc_result_t want;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = idle_cycles(snk_calm);
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (res_ch.valid !== 1'b1);
			got = '{res_ch.payload_byte, res_ch.payload_valid, res_ch.payload_index,
				res_ch.done_res, res_ch.packet_ok, res_ch.too_short, res_ch.lead_word,
				res_ch.origin_host, res_ch.action_word, res_ch.received_sum};
			if (expect_q.size() == 0) begin
				$error("result item arrived with nothing expected");
				error_count++;
			end else begin
				want = expect_q.pop_front();
				checked_results++;
				if (want.done_res) begin
					packets_seen++;
					ok_count += int'(want.packet_ok);
					short_count += int'(want.too_short);
				end
				field_check("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
				field_check("payload_valid", 16'(want.payload_valid),
					16'(got.payload_valid));
				field_check("payload_index", 16'(want.payload_index),
					16'(got.payload_index));
				field_check("done_res", 16'(want.done_res), 16'(got.done_res));
				field_check("packet_ok", 16'(want.packet_ok), 16'(got.packet_ok));
				field_check("too_short", 16'(want.too_short), 16'(got.too_short));
				field_check("lead_word", want.lead_word, got.lead_word);
				field_check("origin_host", 16'(want.origin_host), 16'(got.origin_host));
				field_check("action_word", want.action_word, got.action_word);
				field_check("received_sum", want.received_sum, got.received_sum);
			end
		end
	end

	// watchdog: too long without any item moving on either stream
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= IdleLimit) begin
			$display("timeout: no item moved for %0d cycles", stall_cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	// stimulus
	initial begin
		bit first;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		rx_ch.valid <= 1'b0;
		rx_ch.rx_byte <= '0;
		rx_ch.last_byte <= 1'b0;
		cur_fmt = FMT_GENERAL;
		byte_cnt = 0;
		sum_acc = '0;
		lead_cap = '0;
		origin_cap = '0;
		action_cap = '0;
		chk_cap = '0;
		error_count = 0;
		checked_results = 0;
		packets_seen = 0;
		ok_count = 0;
		short_count = 0;
		fmt_writes = 0;
		directed_items = 0;
		random_items = 0;
		src_calm = 0;
		snk_calm = 0;
		stall_cycles = 0;

		// one-byte packet straight after reset: too short, lead high byte only
		plan.push_back(row(ROW_BYTE, 8'hAB, 1'b1, 1'b1, packet_status(8'h00, 1'b0, 8'h00,
			1'b0, 1'b1, 16'hAB00, 8'h00, 16'h0000, 16'h0000)));
		// general layout, all-ones lead word and payload byte, sum wraps past 16 bits and matches
		plan.push_back(row(ROW_BYTE, 8'hFF));
		plan.push_back(row(ROW_BYTE, 8'hFF));
		plan.push_back(row(ROW_BYTE, 8'h00));
		plan.push_back(row(ROW_BYTE, 8'h01));
		plan.push_back(row(ROW_BYTE, 8'h00));
		plan.push_back(row(ROW_BYTE, 8'hFF));
		plan.push_back(row(ROW_BYTE, 8'hFF, 1'b1, 1'b1, packet_status(8'hFF, 1'b1, 8'h00,
			1'b1, 1'b0, 16'hFFFF, 8'h00, 16'h0001, 16'h00FF)));
		// header only, nothing missing, checksum wrong
		plan.push_back(row(ROW_BYTE, 8'h00));
		plan.push_back(row(ROW_BYTE, 8'h00));
		plan.push_back(row(ROW_BYTE, 8'h00));
		plan.push_back(row(ROW_BYTE, 8'h00));
		plan.push_back(row(ROW_BYTE, 8'h12));
		plan.push_back(row(ROW_BYTE, 8'h34, 1'b1, 1'b1, packet_status(8'h00, 1'b0, 8'h00,
			1'b0, 1'b0, 16'h0000, 8'h00, 16'h0000, 16'h1234)));
		// admin layout with origin octet and one payload byte
		plan.push_back(row(ROW_FORMAT, 8'(FMT_ADMIN)));
		plan.push_back(row(ROW_BYTE, 8'h01));
		plan.push_back(row(ROW_BYTE, 8'h02));
		plan.push_back(row(ROW_BYTE, 8'h80));
		plan.push_back(row(ROW_BYTE, 8'h7F));
		plan.push_back(row(ROW_BYTE, 8'hFF));
		plan.push_back(row(ROW_BYTE, 8'h81));
		plan.push_back(row(ROW_BYTE, 8'h82));
		plan.push_back(row(ROW_BYTE, 8'h01, 1'b1, 1'b1, packet_status(8'h01, 1'b1, 8'h00,
			1'b1, 1'b0, 16'h0102, 8'h80, 16'h7FFF, 16'h8182)));
		// format flips back to general inside a packet that then ends short
		plan.push_back(row(ROW_BYTE, 8'h12));
		plan.push_back(row(ROW_FORMAT, 8'(FMT_GENERAL)));
		plan.push_back(row(ROW_BYTE, 8'h34));
		plan.push_back(row(ROW_BYTE, 8'h56, 1'b1));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_FORMAT) begin
				write_format(plan[i].data[0]);
			end else begin
				send_byte(plan[i].data, plan[i].last, plan[i].typed, plan[i].want);
				directed_items++;
			end
		end

		// random packets; the first one overruns the payload area
		first = 1'b1;
		while (random_items < RandomItems) begin
			case ($urandom_range(0, 9))
				0: write_format(1'($urandom));
				1: drain();
				default: ;
			endcase
			random_packet(first);
			first = 1'b0;
		end

		drain();
		repeat (TailCycles) @(posedge clk);

		$display("Covered %0d directed and %0d random bytes, %0d results checked, %0d format writes.",
			directed_items, random_items, checked_results, fmt_writes);
		$display("Packets: %0d total, %0d with a good checksum, %0d cut short in the header.",
			packets_seen, ok_count, short_count);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
